>>> design/xfd_pkg.sv
package xfd_pkg;

	localparam int DATA_W = 8;
	localparam int LEN_W  = 5;
	localparam int KIND_W = 2;

	localparam logic [DATA_W-1:0] MARKER_RST = 8'd10;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY    = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DETECT,
		ST_CHECK,
		ST_EMIT,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic              shift;
		logic [DATA_W-1:0] data;
	} chain_ctl_t;

endpackage

>>> design/xfd_if.sv
interface xfd_rx_if;
	import xfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] rx_byte;
	logic              line_error;

	modport source(output valid, rx_byte, line_error, input ready);
	modport sink(input valid, rx_byte, line_error, output ready);
endinterface

interface xfd_res_if;
	import xfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [DATA_W-1:0] data_byte;
	logic [LEN_W-1:0]  byte_index;
	logic [LEN_W-1:0]  frame_length;
	logic              last;

	modport source(output valid, kind, data_byte, byte_index, frame_length, last, input ready);
	modport sink(input valid, kind, data_byte, byte_index, frame_length, last, output ready);
endinterface

interface xfd_cfg_if;
	import xfd_pkg::*;

	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] end_marker;

	modport source(output valid, end_marker, input ready);
	modport sink(input valid, end_marker, output ready);
endinterface

>>> design/xfd_cell.sv
module xfd_cell (
	input  logic                       clk,
	input  logic                       en,
	input  logic [xfd_pkg::DATA_W-1:0] d,
	output logic [xfd_pkg::DATA_W-1:0] q
);
	import xfd_pkg::*;

	logic [DATA_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;
endmodule

>>> design/xfd_ctrl.sv
module xfd_ctrl #(
	parameter int RING_DEPTH  = 64,
	parameter int MAX_PAYLOAD = 19
) (
	input  logic                       clk,
	input  logic                       arst_n,
	xfd_rx_if.sink                     rx,
	xfd_res_if.source                  res,
	input  logic [xfd_pkg::DATA_W-1:0] end_marker,
	input  logic [xfd_pkg::DATA_W-1:0] cells [MAX_PAYLOAD+3],
	output xfd_pkg::chain_ctl_t        chain
);
	import xfd_pkg::*;

	localparam int NCELL = MAX_PAYLOAD + 3;
	localparam int IDX_W = $clog2(NCELL);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int CMP_W = ((CNT_W > DATA_W) ? CNT_W : DATA_W) + 1;

	state_t            state_q, state_nxt;
	logic [CNT_W-1:0]  count_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  i_q;
	logic [DATA_W-1:0] acc_q;
	kind_t             res_kind_q;

	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [DATA_W-1:0] out_data_q;
	logic [LEN_W-1:0]  out_idx_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;

	logic              take;
	logic              good;
	logic [CNT_W-1:0]  cnt_inc;
	logic              ovf;
	logic              is_mark;
	logic              len_ok;
	logic              sum_ok;
	logic              walk_done;
	logic              emit_last;
	logic              free;
	logic              load;
	logic [LEN_W:0]    rd_full;
	logic [IDX_W-1:0]  rd_idx;
	logic [DATA_W-1:0] rd_byte;

	assign take      = rx.valid && rx.ready;
	assign good      = take && !rx.line_error;
	assign cnt_inc   = count_q + CNT_W'(1);
	assign ovf       = cnt_inc >= CNT_W'(RING_DEPTH);
	assign is_mark   = (rx.rx_byte == end_marker) && (cnt_inc >= CNT_W'(3));
	assign len_ok    = (cells[2] <= DATA_W'(MAX_PAYLOAD))
	                && (CMP_W'(count_q) >= CMP_W'(cells[2]) + CMP_W'(3));
	assign walk_done = (i_q == len_q);
	assign sum_ok    = (acc_q == cells[1]);
	assign emit_last = ((i_q + LEN_W'(1)) == len_q);
	assign free      = !out_valid_q || res.ready;

	// oldest payload byte sits deepest in the chain
	assign rd_full = (LEN_W+1)'(len_q) + (LEN_W+1)'(2) - (LEN_W+1)'(i_q);
	assign rd_idx  = rd_full[IDX_W-1:0];
	assign rd_byte = cells[rd_idx];

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (good && ovf) begin
					state_nxt = ST_RESULT;
				end else if (good && is_mark) begin
					state_nxt = ST_DETECT;
				end
			end
			ST_DETECT: begin
				state_nxt = len_ok ? ST_CHECK : ST_IDLE;
			end
			ST_CHECK: begin
				if (walk_done) begin
					if (!sum_ok) begin
						state_nxt = ST_IDLE;
					end else if (len_q == '0) begin
						state_nxt = ST_RESULT;
					end else begin
						state_nxt = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (free && emit_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		rx.ready    = (state_q == ST_IDLE);
		load        = free && ((state_q == ST_EMIT) || (state_q == ST_RESULT));
		chain.shift = good;
		chain.data  = rx.rx_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_IDLE && good) begin
				count_q <= ovf ? '0 : cnt_inc;
			end else if (state_q == ST_CHECK && walk_done && sum_ok) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				res_kind_q <= KIND_OVERFLOW;
			end
			ST_DETECT: begin
				len_q <= LEN_W'(cells[2]);
				acc_q <= cells[2];
				i_q   <= '0;
			end
			ST_CHECK: begin
				if (!walk_done) begin
					acc_q <= acc_q ^ rd_byte;
					i_q   <= i_q + LEN_W'(1);
				end else begin
					i_q        <= '0;
					res_kind_q <= KIND_EMPTY;
				end
			end
			ST_EMIT: begin
				if (free) begin
					i_q <= i_q + LEN_W'(1);
				end
			end
			ST_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (state_q == ST_EMIT) begin
				out_kind_q <= KIND_PAYLOAD;
				out_data_q <= rd_byte;
				out_idx_q  <= i_q;
				out_len_q  <= len_q;
				out_last_q <= emit_last;
			end else begin
				out_kind_q <= res_kind_q;
				out_data_q <= '0;
				out_idx_q  <= '0;
				out_len_q  <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = out_kind_q;
	assign res.data_byte    = out_data_q;
	assign res.byte_index   = out_idx_q;
	assign res.frame_length = out_len_q;
	assign res.last         = out_last_q;
endmodule

>>> design/xor_frame_deframer.sv
// Receiver for frames laid out as payload, length, XOR checksum, end marker. Good bytes shift
// into a row of MAX_PAYLOAD+3 byte cells, the deepest reach of any frame; a byte with
// line_error set is dropped. Bytes are taken only while the block is idle. When the stored byte
// equals end_marker, the block checks the length, then walks the checksum through one read port
// on the cell row, and then gives out the payload bytes while the result port takes them;
// rx.ready stays low until the frame is done. Each payload byte is one transfer on res, last
// marks the final one; an empty frame gives one kind 1 transfer. When the byte count reaches
// RING_DEPTH the count is cleared and one kind 2 transfer reports the overflow. end_marker resets
// to 10 and is to be written through cfg only while the block is idle; the block itself does
// not enforce this.
module xor_frame_deframer #(
	parameter int RING_DEPTH  = 64,
	parameter int MAX_PAYLOAD = 19
) (
	input  logic      clk,
	input  logic      arst_n,
	xfd_rx_if.sink    rx,
	xfd_res_if.source res,
	xfd_cfg_if.sink   cfg
);
	import xfd_pkg::*;

	localparam int NCELL = MAX_PAYLOAD + 3;

	logic [DATA_W-1:0] end_marker_q;
	logic [DATA_W-1:0] cell_q [NCELL];
	chain_ctl_t        chain;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_marker_q <= MARKER_RST;
		end else if (cfg.valid) begin
			end_marker_q <= cfg.end_marker;
		end
	end

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k == 0) begin : g_head
			xfd_cell u_cell (
				.clk (clk),
				.en  (chain.shift),
				.d   (chain.data),
				.q   (cell_q[k])
			);
		end else begin : g_body
			xfd_cell u_cell (
				.clk (clk),
				.en  (chain.shift),
				.d   (cell_q[k-1]),
				.q   (cell_q[k])
			);
		end
	end

	xfd_ctrl #(
		.RING_DEPTH  (RING_DEPTH),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.res        (res),
		.end_marker (end_marker_q),
		.cells      (cell_q),
		.chain      (chain)
	);
endmodule

>>> tb/sv/xfd_checker.sv
module xfd_checker #(
	parameter int RING_DEPTH  = 64,
	parameter int MAX_PAYLOAD = 19
) (
	input  logic clk,
	input  logic arst_n,
	xfd_rx_if    rx,
	xfd_res_if   res,
	xfd_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);
	import xfd_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [DATA_W-1:0] data_byte;
		logic [LEN_W-1:0]  byte_index;
		logic [LEN_W-1:0]  frame_length;
		logic              last;
	} deframed_t;

	logic [DATA_W-1:0] ring [RING_DEPTH];
	int unsigned       wr_pos;
	int unsigned       fill;
	logic [DATA_W-1:0] marker;
	deframed_t         deframed_q [$];

	function automatic logic [DATA_W-1:0] behind(int unsigned k);
		return ring[(wr_pos + RING_DEPTH - k) % RING_DEPTH];
	endfunction

	function automatic void add_result(kind_t k, logic [DATA_W-1:0] d, logic [LEN_W-1:0] idx,
			logic [LEN_W-1:0] len, logic fin);
		deframed_t r;
		r.kind         = k;
		r.data_byte    = d;
		r.byte_index   = idx;
		r.frame_length = len;
		r.last         = fin;
		deframed_q.push_back(r);
	endfunction

	function automatic void deframe_byte(logic [DATA_W-1:0] b);
		int unsigned       len;
		logic [DATA_W-1:0] sum;
		ring[wr_pos] = b;
		wr_pos = (wr_pos + 1) % RING_DEPTH;
		fill++;
		if (fill >= RING_DEPTH) begin
			wr_pos = 0;
			fill = 0;
			add_result(KIND_OVERFLOW, '0, '0, '0, 1'b1);
			return;
		end
		if (b != marker || fill < 3)
			return;
		len = 32'(behind(3));
		if (len > MAX_PAYLOAD || fill < len + 3)
			return;
		sum = behind(3);
		for (int unsigned i = 0; i < len; i++)
			sum ^= behind(3 + len - i);
		if (sum != behind(2))
			return;
		if (len == 0) begin
			fill = 0;
			add_result(KIND_EMPTY, '0, '0, '0, 1'b1);
			return;
		end
		for (int unsigned i = 0; i < len; i++)
			add_result(KIND_PAYLOAD, behind(3 + len - i), LEN_W'(i), LEN_W'(len), i + 1 == len);
		fill = 0;
	endfunction

	function automatic void check_field(string name, logic [DATA_W-1:0] want,
			logic [DATA_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0d, actual %0d", name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		deframed_t want;
		if (!arst_n) begin
			wr_pos = 0;
			fill = 0;
			marker = MARKER_RST;
			deframed_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready)
				marker = cfg.end_marker;
			if (rx.valid && rx.ready && !rx.line_error)
				deframe_byte(rx.rx_byte);
			if (res.valid && res.ready) begin
				if (deframed_q.size() == 0) begin
					fail_count++;
					$error("result transfer with nothing pending: kind %0d", res.kind);
				end else begin
					want = deframed_q.pop_front();
					check_field("kind", DATA_W'(want.kind), DATA_W'(res.kind));
					check_field("data_byte", want.data_byte, res.data_byte);
					check_field("byte_index", DATA_W'(want.byte_index),
						DATA_W'(res.byte_index));
					check_field("frame_length", DATA_W'(want.frame_length),
						DATA_W'(res.frame_length));
					check_field("last", DATA_W'(want.last), DATA_W'(res.last));
				end
			end
			pending <= deframed_q.size();
		end
	end

endmodule

>>> tb/sv/tb_xor_frame_deframer.sv
module tb_xor_frame_deframer;
	import xfd_pkg::*;

	localparam int PERIOD      = 8;
	localparam int RING_DEPTH  = 64;
	localparam int MAX_PAYLOAD = 19;
	localparam int LONG_HOLD   = 100;
	localparam int SETTLE      = 48;
	localparam int STALL_LIMIT = 1000;
	localparam int RUN_LIMIT   = 200000;

	typedef enum {FLAW_NONE, FLAW_CHECKSUM, FLAW_TRUNCATE, FLAW_LENGTH} flaw_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	xfd_rx_if  rx();
	xfd_res_if res();
	xfd_cfg_if cfg();

	int                fail_count;
	int                pending;
	bit                idle_on;
	bit                long_hold;
	logic [DATA_W-1:0] cur_marker;
	int                sent;
	int                quiet;
	int                cycles;

	xor_frame_deframer #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.res   (res),
		.cfg   (cfg)
	);

	xfd_checker #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.res       (res),
		.cfg       (cfg),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #(PERIOD / 2) clk = ~clk;

	task automatic offer(input logic [DATA_W-1:0] b, input logic err);
		int gap;
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			rx.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx.valid <= 1'b1;
		rx.rx_byte <= b;
		rx.line_error <= err;
		do @(posedge clk); while (rx.ready !== 1'b1);
	endtask

	// good byte, sometimes preceded by a byte with a line error
	task automatic put_byte(input logic [DATA_W-1:0] b);
		if ($urandom_range(0, 11) == 0)
			offer(DATA_W'($urandom), 1'b1);
		offer(b, 1'b0);
		sent++;
	endtask

	task automatic send_frame(input int unsigned len, input flaw_t flaw);
		logic [DATA_W-1:0] body [$];
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] len_byte;
		int unsigned       keep;
		len_byte = DATA_W'(len);
		if (flaw == FLAW_LENGTH)
			len_byte = DATA_W'($urandom_range(MAX_PAYLOAD + 1, 255));
		sum = len_byte;
		for (int unsigned i = 0; i < len; i++) begin
			body.push_back(DATA_W'($urandom));
			sum ^= body[i];
		end
		if (flaw == FLAW_CHECKSUM)
			sum ^= DATA_W'($urandom_range(1, 255));
		keep = (flaw == FLAW_TRUNCATE) ? len / 2 : len;
		for (int unsigned i = 0; i < keep; i++)
			put_byte(body[i]);
		put_byte(len_byte);
		put_byte(sum);
		put_byte(cur_marker);
	endtask

	function automatic int unsigned frame_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return MAX_PAYLOAD;
			2: return $urandom_range(7, MAX_PAYLOAD - 1);
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	task automatic run_phase(input int target, input bit flood);
		int first;
		int pick;
		first = sent;
		while (sent - first < target) begin
			pick = $urandom_range(0, 19);
			if (flood && sent - first >= target / 3) begin
				// marker-free run long enough to wrap the ring
				flood = 1'b0;
				repeat (RING_DEPTH) put_byte(DATA_W'(cur_marker + $urandom_range(1, 255)));
			end else if (pick < 13) begin
				send_frame(frame_len(), FLAW_NONE);
			end else if (pick < 16) begin
				send_frame(frame_len(), flaw_t'($urandom_range(1, 3)));
			end else begin
				repeat ($urandom_range(1, 4)) put_byte(DATA_W'($urandom));
			end
		end
	endtask

	task automatic settle();
		rx.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_marker(input logic [DATA_W-1:0] v);
		cfg.valid <= 1'b1;
		cfg.end_marker <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		cur_marker = v;
	endtask

	initial begin
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
				res.ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 3) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				res.ready <= 1'b1;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((rx.valid && rx.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		cycles <= cycles + 1;
		if (quiet >= STALL_LIMIT || cycles >= RUN_LIMIT) begin
			$display("** xor_frame_deframer: FAILED **");
			$finish;
		end
	end

	initial begin
		rx.valid = 1'b0;
		rx.rx_byte = '0;
		rx.line_error = 1'b0;
		cfg.valid = 1'b0;
		cfg.end_marker = '0;
		quiet = 0;
		cycles = 0;
		sent = 0;
		idle_on = 1'b1;
		long_hold = 1'b0;
		cur_marker = MARKER_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty frame
		offer(8'h00, 1'b0);
		offer(8'h00, 1'b0);
		offer(cur_marker, 1'b0);
		// marker with line error is dropped
		offer(cur_marker, 1'b1);
		// too few bytes stored for the length
		offer(8'h03, 1'b0);
		offer(8'h03, 1'b0);
		offer(cur_marker, 1'b0);
		// one-byte frame
		offer(8'hFF, 1'b0);
		offer(8'h01, 1'b0);
		offer(8'hFE, 1'b0);
		offer(cur_marker, 1'b0);
		// checksum mismatch
		offer(8'h55, 1'b0);
		offer(8'h01, 1'b0);
		offer(8'h55, 1'b0);
		offer(cur_marker, 1'b0);
		// length over the limit
		offer(8'h14, 1'b0);
		offer(8'h14, 1'b0);
		offer(cur_marker, 1'b0);
		send_frame(3, FLAW_NONE);

		settle();
		write_marker(8'hFF);
		run_phase(8, 1'b0);

		settle();
		write_marker(8'h00);
		long_hold = 1'b1;
		send_frame(MAX_PAYLOAD, FLAW_NONE);
		run_phase(2, 1'b1);

		settle();
		write_marker(DATA_W'($urandom_range(1, 254)));
		idle_on = 1'b0;
		run_phase(8, 1'b0);

		settle();
		if (fail_count == 0 && pending == 0)
			$display("** xor_frame_deframer: PASSED **");
		else
			$display("** xor_frame_deframer: FAILED **");
		$finish;
	end

endmodule
